// ----- src/dsepc_pkg.sv -----
// ----------------------------------------------------------------------------
// dsepc_pkg
// Shared types, register map and command codes for the dual serial EEPROM
// port controller.
// ----------------------------------------------------------------------------
package dsepc_pkg;

	localparam int INT_BYTES_DEF = 2048;
	localparam int EXT_BYTES_DEF = 2048;

	localparam logic [3:0] CODE_MIN = 4'd7;
	localparam logic [3:0] CODE_MAX = 4'd11;

	localparam logic [7:0] REG_INT_BASE = 8'hBA;
	localparam logic [7:0] REG_EXT_BASE = 8'hC4;
	localparam logic [7:0] REG_SPAN     = 8'd4;

	localparam logic [15:0] ERASED_WORD = 16'hFFFF;
	// byte address 0x30 as a word index
	localparam logic [15:0] LOCK_WORD   = 16'h0018;

	typedef enum logic [1:0] {
		FUNC_READ  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_LOCK  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [0:0] {
		CFG_IS_COLOR = 1'b0,
		CFG_EXT_SIZE = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OFS_DATA_LO = 3'd0,
		OFS_DATA_HI = 3'd1,
		OFS_ADDR_LO = 3'd2,
		OFS_ADDR_HI = 3'd3,
		OFS_CMD     = 3'd4
	} reg_ofs_t;

	typedef enum logic [2:0] {
		OP_EXT   = 3'b100,
		OP_WRITE = 3'b101,
		OP_READ  = 3'b110,
		OP_ERASE = 3'b111
	} eep_op_t;

	typedef enum logic [1:0] {
		EXT_EWDS = 2'd0,
		EXT_WRAL = 2'd1,
		EXT_ERAL = 2'd2,
		EXT_EWEN = 2'd3
	} ext_sub_t;

	// one register access handed from the bus decode to a port
	typedef struct packed {
		logic       wr;
		logic       cmd;
		logic       lock;
		reg_ofs_t   ofs;
		logic [7:0] wdata;
	} port_req_t;

	// elaboration only: floor(log2(n))
	function automatic int floor_log2(input int n);
		int r;
		r = 0;
		while ((2 ** (r + 1)) <= n) r = r + 1;
		return r;
	endfunction

	function automatic logic [3:0] clamp_code(input logic [3:0] c, input logic [3:0] lim);
		logic [3:0] r;
		r = c;
		if (r < CODE_MIN) r = CODE_MIN;
		if (r > CODE_MAX) r = CODE_MAX;
		if (r > lim) r = lim;
		return r;
	endfunction

endpackage

// ----- src/dsepc_ram.sv -----
// ----------------------------------------------------------------------------
// dsepc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsepc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/dsepc_port.sv -----
// ----------------------------------------------------------------------------
// dsepc_port
// One EEPROM port: data/address/command registers, word store and the
// command sequencer (decode, single-word access, store-wide sweep).
// ----------------------------------------------------------------------------
module dsepc_port
	import dsepc_pkg::*;
#(
	parameter int          BYTES  = INT_BYTES_DEF,
	parameter bit          IS_INT = 1'b1,
	parameter logic [15:0] FILL   = ERASED_WORD
) (
	input  logic      clk,
	input  logic      arst_n,
	input  port_req_t req,
	input  logic [3:0] code,
	output logic      busy,
	output logic [7:0] rd_byte
);

	localparam int DEPTH = BYTES / 2;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_DECODE = 5'b00100,
		S_READ   = 5'b01000,
		S_FILL   = 5'b10000
	} port_state_t;

	port_state_t state_q;
	logic [AW-1:0] cnt_q, cnt_last_q;
	logic [15:0] data_q, addr_q, fill_q;
	logic [7:0]  cmd_q;
	logic lock_q, wdis_q, done_q, rdone_q;

	logic [2:0]  sel;
	logic        sel_ok, lock_now, unlocked, is_fill, is_rd;
	logic [15:0] data_op, word_mask, word, sh;
	eep_op_t     op;
	ext_sub_t    sub;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata, ram_rdata;

	always_comb begin
		sel = cmd_q[6:4];
		case (sel)
			3'b001, 3'b010, 3'b100: sel_ok = 1'b1;
			default:                sel_ok = 1'b0;
		endcase
		lock_now  = lock_q | cmd_q[7];
		data_op   = cmd_q[5] ? data_q : ERASED_WORD;
		word_mask = (16'd1 << 4'(code - 4'd1)) - 16'd1;
		word      = addr_q & word_mask;
		sh        = addr_q >> 4'(code - 4'd3);
		op        = eep_op_t'(sh[4:2]);
		sub       = ext_sub_t'(sh[1:0]);
		unlocked  = !wdis_q && !(IS_INT && lock_now && (word >= LOCK_WORD));
		is_rd     = (op == OP_READ) && cmd_q[4];
		is_fill   = (op == OP_EXT) && (sub == EXT_WRAL || sub == EXT_ERAL) && unlocked;
	end

	// store port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = fill_q;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = FILL;
			end
			S_FILL: ram_we = 1'b1;
			S_DECODE: begin
				ram_we    = sel_ok && unlocked && (op == OP_WRITE || op == OP_ERASE);
				ram_waddr = word[AW-1:0];
				ram_wdata = (op == OP_WRITE) ? data_op : ERASED_WORD;
			end
			default: ;
		endcase
		ram_re = (state_q == S_DECODE) && sel_ok && is_rd;
	end

	dsepc_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (word[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			cnt_q      <= '0;
			cnt_last_q <= '0;
			data_q     <= '0;
			addr_q     <= '0;
			cmd_q      <= '0;
			fill_q     <= '0;
			lock_q     <= 1'b0;
			wdis_q     <= 1'b0;
			done_q     <= 1'b0;
			rdone_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.wr) begin
						case (req.ofs)
							OFS_DATA_LO: data_q[7:0]  <= req.wdata;
							OFS_DATA_HI: data_q[15:8] <= req.wdata;
							OFS_ADDR_LO: addr_q[7:0]  <= req.wdata;
							OFS_ADDR_HI: addr_q[15:8] <= req.wdata;
							default: ;
						endcase
					end
					if (req.lock) begin
						lock_q <= req.wdata[0];
					end
					if (req.cmd) begin
						cmd_q   <= req.wdata;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					lock_q  <= lock_now;
					state_q <= S_IDLE;
					if (sel_ok) begin
						done_q  <= 1'b1;
						rdone_q <= cmd_q[4];
						if (op == OP_EXT && sub == EXT_EWDS) wdis_q <= 1'b1;
						if (op == OP_EXT && sub == EXT_EWEN) wdis_q <= 1'b0;
						if (cmd_q[4] && op != OP_READ) data_q <= data_op;
						if (is_rd) begin
							state_q <= S_READ;
						end else if (is_fill) begin
							fill_q     <= (sub == EXT_WRAL) ? data_op : ERASED_WORD;
							cnt_q      <= '0;
							cnt_last_q <= word_mask[AW-1:0];
							state_q    <= S_FILL;
						end
					end
				end
				S_READ: begin
					data_q  <= ram_rdata;
					state_q <= S_IDLE;
				end
				S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == cnt_last_q) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		case (req.ofs)
			OFS_DATA_LO: rd_byte = data_q[7:0];
			OFS_DATA_HI: rd_byte = data_q[15:8];
			OFS_ADDR_LO: rd_byte = addr_q[7:0];
			OFS_ADDR_HI: rd_byte = addr_q[15:8];
			OFS_CMD:     rd_byte = {6'b111111, done_q, rdone_q};
			default:     rd_byte = 8'h00;
		endcase
	end

	a_req_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.cmd || req.wr || req.lock) |-> state_q == S_IDLE)
		else $error("port transaction while sequencer busy");

	a_read_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_IDLE)
		else $error("read state held more than one cycle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> cnt_q <= cnt_last_q)
		else $error("sweep counter past last word");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ram_we)
		else $error("store written while idle");

endmodule

// ----- src/dual_serial_eeprom_port_controller.sv -----
// ----------------------------------------------------------------------------
// dual_serial_eeprom_port_controller
// Two 93Cxx-style EEPROM ports behind byte-wide data, address and command
// registers (internal at 0xBA-0xBE, external at 0xC4-0xC8).
//
// Input channel (in_valid/in_ready): func, reg_addr, write_data. A register
// read returns one byte on the output channel (out_valid/out_ready) in the
// cycle after the transaction; writes and lock requests return nothing.
// A command write keeps the block busy through the decode state, then the
// store read state for a read, or the sweep state for write-all/erase-all,
// which writes 2^(code-1) words, one word per cycle, through the single
// store write port. in_ready stays low while either port sequencer is busy.
// After reset both stores are cleared (internal to 0xFFFF, external to 0)
// one word per cycle, INT_BYTES/2 and EXT_BYTES/2 words, with in_ready low
// until both are done. Configuration (cfg_valid/cfg_ready) is always taken.
// A stalled read result is held in the output register; a new transaction
// is taken only once that result leaves.
// ----------------------------------------------------------------------------
module dual_serial_eeprom_port_controller
	import dsepc_pkg::*;
#(
	parameter int INT_BYTES = INT_BYTES_DEF,
	parameter int EXT_BYTES = EXT_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data
);

	localparam logic [3:0] INT_LIM = 4'(floor_log2(INT_BYTES));
	localparam logic [3:0] EXT_LIM = 4'(floor_log2(EXT_BYTES));

	logic       is_color_q;
	logic [3:0] ext_size_q;
	logic       out_valid_q;
	logic [7:0] read_data_q;

	logic       accept, int_hit, ext_hit, int_busy, ext_busy;
	logic [7:0] int_diff, ext_diff, int_byte, ext_byte;
	logic [3:0] int_code, ext_code;
	port_req_t  int_req, ext_req;
	func_t      fn;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_color_q <= 1'b1;
			ext_size_q <= CODE_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IS_COLOR: is_color_q <= cfg_data[0];
				CFG_EXT_SIZE: ext_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign int_code = clamp_code(is_color_q ? CODE_MAX : CODE_MIN, INT_LIM);
	assign ext_code = clamp_code(ext_size_q, EXT_LIM);

	assign in_ready = !int_busy && !ext_busy && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign fn       = func_t'(func);

	assign int_diff = reg_addr - REG_INT_BASE;
	assign ext_diff = reg_addr - REG_EXT_BASE;
	assign int_hit  = (reg_addr >= REG_INT_BASE) && (int_diff <= REG_SPAN);
	assign ext_hit  = (reg_addr >= REG_EXT_BASE) && (ext_diff <= REG_SPAN);

	always_comb begin
		int_req       = '0;
		ext_req       = '0;
		int_req.ofs   = reg_ofs_t'(int_diff[2:0]);
		ext_req.ofs   = reg_ofs_t'(ext_diff[2:0]);
		int_req.wdata = write_data;
		ext_req.wdata = write_data;
		if (accept) begin
			case (fn)
				FUNC_WRITE: begin
					int_req.wr  = int_hit && (int_req.ofs != OFS_CMD);
					int_req.cmd = int_hit && (int_req.ofs == OFS_CMD);
					ext_req.wr  = ext_hit && (ext_req.ofs != OFS_CMD);
					ext_req.cmd = ext_hit && (ext_req.ofs == OFS_CMD);
				end
				FUNC_LOCK: int_req.lock = 1'b1;
				default: ;
			endcase
		end
	end

	dsepc_port #(
		.BYTES  (INT_BYTES),
		.IS_INT (1'b1),
		.FILL   (ERASED_WORD)
	) u_int (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (int_req),
		.code    (int_code),
		.busy    (int_busy),
		.rd_byte (int_byte)
	);

	dsepc_port #(
		.BYTES  (EXT_BYTES),
		.IS_INT (1'b0),
		.FILL   (16'h0000)
	) u_ext (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ext_req),
		.code    (ext_code),
		.busy    (ext_busy),
		.rd_byte (ext_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && fn == FUNC_READ) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fn == FUNC_READ) begin
			read_data_q <= int_hit ? int_byte : (ext_hit ? ext_byte : 8'h00);
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule
